### rtl/core/tapc_pkg.sv
`timescale 1ns / 1ps

package tapc_pkg;

  // internal error width: wide enough for every target, offset and heading
  localparam int ERR_W = 17;
  localparam int TGT_W = 16;
  localparam int THR_W = 7;
  localparam int OFS_W = 8;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic signed [TGT_W-1:0] WEIGHT_HUNDREDS = 16'sd100;
  localparam logic signed [TGT_W-1:0] WEIGHT_TENS     = 16'sd10;

  localparam logic signed [ERR_W-1:0] WRAP_HALF = 17'sd180;
  localparam logic signed [ERR_W-1:0] WRAP_FULL = 17'sd360;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 7'd6;

  // configuration register indexes
  localparam logic REG_START_THRESHOLD  = 1'b0;
  localparam logic REG_ELEVATION_OFFSET = 1'b1;

  // drive request of one axis
  typedef struct packed {
    logic pos;
    logic neg;
  } axis_drive_t;

endpackage

### rtl/core/tapc_digits.sv
`timescale 1ns / 1ps

module tapc_digits
  import tapc_pkg::*;
(
  input  logic [7:0]              char_hundreds,
  input  logic [7:0]              char_tens,
  input  logic [7:0]              char_ones,
  output logic signed [TGT_W-1:0] value
);

  logic signed [TGT_W-1:0] d_hundreds;
  logic signed [TGT_W-1:0] d_tens;
  logic signed [TGT_W-1:0] d_ones;

  // non-digit bytes go through the same formula
  assign d_hundreds = $signed({8'b0, char_hundreds}) - $signed({8'b0, ASCII_ZERO});
  assign d_tens     = $signed({8'b0, char_tens})     - $signed({8'b0, ASCII_ZERO});
  assign d_ones     = $signed({8'b0, char_ones})     - $signed({8'b0, ASCII_ZERO});

  assign value = d_hundreds * WEIGHT_HUNDREDS + d_tens * WEIGHT_TENS + d_ones;

endmodule

### rtl/core/tapc_axis.sv
`timescale 1ns / 1ps

module tapc_axis
  import tapc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic signed [ERR_W-1:0] err,
  input  logic [THR_W-1:0]        threshold,
  output axis_drive_t             drive
);

  logic running;
  logic dir_pos;
  logic running_next;
  logic dir_pos_next;

  logic signed [ERR_W-1:0] thr;
  logic signed [ERR_W-1:0] half;

  assign thr  = $signed({{(ERR_W-THR_W){1'b0}}, threshold});
  assign half = $signed({{(ERR_W-THR_W+1){1'b0}}, threshold[THR_W-1:1]});

  always_comb begin
    running_next = running;
    dir_pos_next = dir_pos;
    if (!running) begin
      if (err > thr) begin
        running_next = 1'b1;
        dir_pos_next = 1'b1;
      end else if (err < -thr) begin
        running_next = 1'b1;
        dir_pos_next = 1'b0;
      end
    end else if ((err < half) && (err > -half)) begin
      // direction bit keeps its value on stop
      running_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      dir_pos <= 1'b0;
    end else if (step) begin
      running <= running_next;
      dir_pos <= dir_pos_next;
    end
  end

  assign drive.pos = running_next & dir_pos_next;
  assign drive.neg = running_next & ~dir_pos_next;

endmodule

### rtl/core/two_axis_hysteresis_pointing_control.sv
`timescale 1ns / 1ps

// two-axis bang-bang pointing control with hysteresis
//
// input channel (in_valid / in_stall): one transaction per control tick with
// the pitch and heading readings and, when cmd_valid is set, six ascii digit
// bytes that replace the azimuth and elevation targets.
// output channel (out_valid / out_stall): one transaction per input
// transaction, in order, with the four drive lines and both errors.
// configuration: cfg_we writes cfg_data to register cfg_index at the clock
// edge (0 start_threshold, 1 elevation_offset); write only while idle.
//
// an accepted transaction passes the input register, then the output
// register, before out_valid; one transaction per cycle sustained while
// out_stall is low. the input register feeds one pass of decode, error and
// hysteresis logic, which updates axis state and the output register.
// reset empties both registers, clears targets and axis state, and loads
// threshold 6 and offset 0.
// a stalled output holds its payload; an empty input register still takes one
// more transaction, then in_stall rises until the output side moves.

module two_axis_hysteresis_pointing_control
  import tapc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [OFS_W-1:0]        cfg_data,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd_valid,
  input  logic [7:0]              az_char_hundreds,
  input  logic [7:0]              az_char_tens,
  input  logic [7:0]              az_char_ones,
  input  logic [7:0]              el_char_hundreds,
  input  logic [7:0]              el_char_tens,
  input  logic [7:0]              el_char_ones,
  input  logic signed [8:0]       measured_pitch,
  input  logic [8:0]              measured_heading,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    drive_el_down,
  output logic                    drive_el_up,
  output logic                    drive_az_cw,
  output logic                    drive_az_ccw,
  output logic signed [15:0]      elevation_error,
  output logic signed [15:0]      azimuth_error
);

  // configuration registers
  logic [THR_W-1:0]        start_threshold;
  logic signed [OFS_W-1:0] elevation_offset;

  // input register
  logic              s1_valid;
  logic              s1_cmd;
  logic [7:0]        s1_az_h, s1_az_t, s1_az_o;
  logic [7:0]        s1_el_h, s1_el_t, s1_el_o;
  logic signed [8:0] s1_pitch;
  logic [8:0]        s1_heading;

  // held targets
  logic signed [TGT_W-1:0] target_azimuth;
  logic signed [TGT_W-1:0] target_elevation;

  logic signed [TGT_W-1:0] cmd_azimuth;
  logic signed [TGT_W-1:0] cmd_elevation;
  logic signed [TGT_W-1:0] tgt_az;
  logic signed [TGT_W-1:0] tgt_el;

  logic signed [ERR_W-1:0] el_err;
  logic signed [ERR_W-1:0] az_raw;
  logic signed [ERR_W-1:0] az_err;

  axis_drive_t el_drive;
  axis_drive_t az_drive;

  logic in_accept;
  logic s1_advance;
  logic step;

  // output register frees when empty or taken this cycle
  assign s1_advance = ~out_valid | ~out_stall;
  assign step       = s1_valid & s1_advance;
  assign in_stall   = s1_valid & ~s1_advance;
  assign in_accept  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold  <= THRESHOLD_RESET;
      elevation_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_THRESHOLD:  start_threshold  <= cfg_data[THR_W-1:0];
        REG_ELEVATION_OFFSET: elevation_offset <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // input register: control cleared at reset, payload loaded on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd     <= cmd_valid;
      s1_az_h    <= az_char_hundreds;
      s1_az_t    <= az_char_tens;
      s1_az_o    <= az_char_ones;
      s1_el_h    <= el_char_hundreds;
      s1_el_t    <= el_char_tens;
      s1_el_o    <= el_char_ones;
      s1_pitch   <= measured_pitch;
      s1_heading <= measured_heading;
    end
  end

  tapc_digits u_az_digits (
    .char_hundreds (s1_az_h),
    .char_tens     (s1_az_t),
    .char_ones     (s1_az_o),
    .value         (cmd_azimuth)
  );

  tapc_digits u_el_digits (
    .char_hundreds (s1_el_h),
    .char_tens     (s1_el_t),
    .char_ones     (s1_el_o),
    .value         (cmd_elevation)
  );

  // a command in this tick applies to this tick's errors
  assign tgt_az = s1_cmd ? cmd_azimuth   : target_azimuth;
  assign tgt_el = s1_cmd ? cmd_elevation : target_elevation;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_azimuth   <= '0;
      target_elevation <= '0;
    end else if (step && s1_cmd) begin
      target_azimuth   <= cmd_azimuth;
      target_elevation <= cmd_elevation;
    end
  end

  assign el_err = ERR_W'(s1_pitch) - ERR_W'(tgt_el) - ERR_W'(elevation_offset);

  // azimuth error wrapped once by a full turn toward zero
  assign az_raw = ERR_W'(tgt_az) - $signed({{(ERR_W-9){1'b0}}, s1_heading});

  always_comb begin
    if (az_raw > WRAP_HALF) begin
      az_err = az_raw - WRAP_FULL;
    end else if (az_raw < -WRAP_HALF) begin
      az_err = az_raw + WRAP_FULL;
    end else begin
      az_err = az_raw;
    end
  end

  // positive elevation error drives down, positive azimuth error clockwise
  tapc_axis u_el_axis (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .err       (el_err),
    .threshold (start_threshold),
    .drive     (el_drive)
  );

  tapc_axis u_az_axis (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .err       (az_err),
    .threshold (start_threshold),
    .drive     (az_drive)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_el_down   <= el_drive.pos;
      drive_el_up     <= el_drive.neg;
      drive_az_cw     <= az_drive.pos;
      drive_az_ccw    <= az_drive.neg;
      elevation_error <= el_err[15:0];
      azimuth_error   <= az_err[15:0];
    end
  end

endmodule

### rtl/core/tapc_checker.sv
`timescale 1ns / 1ps

module tapc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              drive_el_down,
  input logic              drive_el_up,
  input logic              drive_az_cw,
  input logic              drive_az_ccw,
  input logic signed [15:0] elevation_error,
  input logic signed [15:0] azimuth_error
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(azimuth_error)
      && $stable(elevation_error) && $stable(drive_el_down) && $stable(drive_az_cw))
    else $error("stalled result changed");

  a_el_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_el_down && drive_el_up))
    else $error("elevation drives both ways");

  a_az_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_az_cw && drive_az_ccw))
    else $error("azimuth drives both ways");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // accepted transaction reaches the output register when the output is not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing after accept");

endmodule

bind two_axis_hysteresis_pointing_control tapc_checker u_tapc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .drive_el_down   (drive_el_down),
  .drive_el_up     (drive_el_up),
  .drive_az_cw     (drive_az_cw),
  .drive_az_ccw    (drive_az_ccw),
  .elevation_error (elevation_error),
  .azimuth_error   (azimuth_error)
);
